/* hdl/sse_pkg.sv */
// Shared request codes, error codes, field widths and token control type for the stack engine.
package sse_pkg;

    // Request codes carried on req_type.
    typedef logic [2:0] req_t;

    localparam req_t REQ_PUSH          = 3'd0;
    localparam req_t REQ_POP           = 3'd1;
    localparam req_t REQ_FIND          = 3'd2;
    localparam req_t REQ_COUNT         = 3'd3;
    localparam req_t REQ_REPLACE_FIRST = 3'd4;
    localparam req_t REQ_REPLACE_ALL   = 3'd5;

    // Error codes carried on error.
    typedef logic [1:0] err_t;

    localparam err_t ERR_NONE  = 2'd0;
    localparam err_t ERR_FULL  = 2'd1;
    localparam err_t ERR_EMPTY = 2'd2;

    // Fixed widths of the result fields.
    localparam int POSITION_W = 4;
    localparam int MATCH_W    = 5;
    localparam int LENGTH_W   = 5;

    // Control part of the search token that walks down the cell chain.
    typedef struct packed {
        logic valid;
        req_t op;
        logic hit;
    } tok_ctl_t;

endpackage

/* hdl/sse_cell.sv */
// One stack cell: holds one entry, shifts on push and pop, and checks the passing search token.
module sse_cell #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift_push,
    input  logic                          shift_pop,
    input  logic [DATA_WIDTH-1:0]         push_data,
    input  logic [DATA_WIDTH-1:0]         pop_data,
    output logic [DATA_WIDTH-1:0]         entry,
    input  sse_pkg::tok_ctl_t             ctl_in,
    input  logic [DATA_WIDTH-1:0]         key_in,
    input  logic [DATA_WIDTH-1:0]         repl_in,
    input  logic [$clog2(DEPTH+1)-1:0]    len_in,
    input  logic [$clog2(DEPTH)-1:0]      pos_in,
    input  logic [$clog2(DEPTH+1)-1:0]    cnt_in,
    output sse_pkg::tok_ctl_t             ctl_out,
    output logic [DATA_WIDTH-1:0]         key_out,
    output logic [DATA_WIDTH-1:0]         repl_out,
    output logic [$clog2(DEPTH+1)-1:0]    len_out,
    output logic [$clog2(DEPTH)-1:0]      pos_out,
    output logic [$clog2(DEPTH+1)-1:0]    cnt_out
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    sse_pkg::tok_ctl_t     ctl_reg;
    sse_pkg::tok_ctl_t     ctl_next;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [DATA_WIDTH-1:0] repl_reg;
    logic [CNT_W-1:0]      len_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [IDX_W-1:0]      pos_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  live;
    logic                  is_match;
    logic                  take_first;
    logic                  do_repl;

    // The token only looks at this cell when the cell lies within the live length.
    always_comb
    begin
        live       = ctl_in.valid && (CNT_W'(INDEX) < len_in);
        is_match   = live && (entry_reg == key_in);
        take_first = is_match && !ctl_in.hit;
        do_repl    = ((ctl_in.op == sse_pkg::REQ_REPLACE_FIRST) && take_first) ||
                     ((ctl_in.op == sse_pkg::REQ_REPLACE_ALL) && is_match);
    end

    // Token update: remember the first hit and count every hit.
    always_comb
    begin
        ctl_next     = ctl_in;
        ctl_next.hit = ctl_in.hit | is_match;
        pos_next     = take_first ? IDX_W'(INDEX) : pos_in;
        cnt_next     = is_match ? cnt_in + CNT_W'(1) : cnt_in;
    end

    // Entry update: push takes the upper neighbor, pop the lower one, replace the new data.
    always_comb
    begin
        if (shift_push)
        begin
            entry_next = push_data;
        end
        else if (shift_pop)
        begin
            entry_next = pop_data;
        end
        else if (do_repl)
        begin
            entry_next = repl_in;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    // Token control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    // Entry and token payload registers.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        key_reg   <= key_in;
        repl_reg  <= repl_in;
        len_reg   <= len_in;
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
    end

    assign entry    = entry_reg;
    assign ctl_out  = ctl_reg;
    assign key_out  = key_reg;
    assign repl_out = repl_reg;
    assign len_out  = len_reg;
    assign pos_out  = pos_reg;
    assign cnt_out  = cnt_reg;

endmodule

/* hdl/searchable_stack_engine_core.sv */
// Searchable stack engine top level: request control, cell chain and result register.
//
// A bounded stack of DEPTH entries of DATA_WIDTH bits, position 0 on top.
// Requests arrive on the input channel (in_valid/in_stall) as req_type, value
// and new_value; a beat is taken when in_valid is high and in_stall is low.
// Each request gives exactly one result beat on the output channel
// (out_valid/out_stall) with found, position, match_count, length and error.
// Push and pop shift every cell of the chain together; their result, like
// that of an unused request code, goes to the result register and then to
// the output register. Find, count and the two replace requests send a
// search token down the chain of DEPTH cells, one cell per cycle; their
// result is taken from the token as it leaves the last cell. One request is
// in work at a time, so a new one is accepted only after the last result has
// been handed over to the output register.
// A request may be accepted while the previous result still waits; its own
// result then holds until the output register frees up.
// When the receiver stalls, the result beat holds steady on the outputs.
// Reset empties the stack (length 0) and drops any result in flight.
module searchable_stack_engine_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   req_type,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic signed [DATA_WIDTH-1:0] new_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         found,
    output logic [3:0]                   position,
    output logic [4:0]                   match_count,
    output logic [4:0]                   length,
    output logic [1:0]                   error
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam int POS_W = sse_pkg::POSITION_W;
    localparam int MCH_W = sse_pkg::MATCH_W;
    localparam int LEN_W = sse_pkg::LENGTH_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              res_found_reg;
    logic              res_found_next;
    logic [POS_W-1:0]  res_pos_reg;
    logic [POS_W-1:0]  res_pos_next;
    logic [MCH_W-1:0]  res_cnt_reg;
    logic [MCH_W-1:0]  res_cnt_next;
    sse_pkg::err_t     res_err_reg;
    sse_pkg::err_t     res_err_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_found_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [MCH_W-1:0]  out_cnt_reg;
    logic [LEN_W-1:0]  out_len_reg;
    sse_pkg::err_t     out_err_reg;
    logic              out_load;
    logic              in_take;
    logic              shift_push;
    logic              shift_pop;

    // Chain wiring: element i feeds cell i, element DEPTH leaves the last cell.
    logic [DATA_WIDTH-1:0] entry_w [DEPTH];
    sse_pkg::tok_ctl_t     ctl_w   [DEPTH+1];
    logic [DATA_WIDTH-1:0] key_w   [DEPTH+1];
    logic [DATA_WIDTH-1:0] repl_w  [DEPTH+1];
    logic [CNT_W-1:0]      len_w   [DEPTH+1];
    logic [IDX_W-1:0]      pos_w   [DEPTH+1];
    logic [CNT_W-1:0]      cnt_w   [DEPTH+1];

    assign in_take = in_valid && !in_stall;

    // A search token enters the top cell straight from the accepted request.
    always_comb
    begin
        ctl_w[0].valid = in_take && (req_type == sse_pkg::REQ_FIND ||
                                     req_type == sse_pkg::REQ_COUNT ||
                                     req_type == sse_pkg::REQ_REPLACE_FIRST ||
                                     req_type == sse_pkg::REQ_REPLACE_ALL);
        ctl_w[0].op    = req_type;
        ctl_w[0].hit   = 1'b0;
        key_w[0]       = value;
        repl_w[0]      = new_value;
        len_w[0]       = count_reg;
        pos_w[0]       = '0;
        cnt_w[0]       = '0;
    end

    // The row of cells.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] push_src;
        logic [DATA_WIDTH-1:0] pop_src;

        if (i == 0)
        begin : g_top
            assign push_src = value;
        end
        else
        begin : g_mid
            assign push_src = entry_w[i-1];
        end

        if (i == DEPTH-1)
        begin : g_bottom
            assign pop_src = entry_w[i];
        end
        else
        begin : g_upper
            assign pop_src = entry_w[i+1];
        end

        sse_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_push (shift_push),
            .shift_pop  (shift_pop),
            .push_data  (push_src),
            .pop_data   (pop_src),
            .entry      (entry_w[i]),
            .ctl_in     (ctl_w[i]),
            .key_in     (key_w[i]),
            .repl_in    (repl_w[i]),
            .len_in     (len_w[i]),
            .pos_in     (pos_w[i]),
            .cnt_in     (cnt_w[i]),
            .ctl_out    (ctl_w[i+1]),
            .key_out    (key_w[i+1]),
            .repl_out   (repl_w[i+1]),
            .len_out    (len_w[i+1]),
            .pos_out    (pos_w[i+1]),
            .cnt_out    (cnt_w[i+1])
        );
    end

    // Request control: decode in idle, wait for the token, then hand over the result.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        res_cnt_next   = res_cnt_reg;
        res_err_next   = res_err_reg;
        shift_push     = 1'b0;
        shift_pop      = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    res_cnt_next   = '0;
                    res_err_next   = sse_pkg::ERR_NONE;
                    state_next     = ST_DONE;
                    unique case (req_type) inside
                        sse_pkg::REQ_PUSH:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_err_next = sse_pkg::ERR_FULL;
                            end
                            else
                            begin
                                shift_push = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        sse_pkg::REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_err_next = sse_pkg::ERR_EMPTY;
                            end
                            else
                            begin
                                shift_pop  = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        sse_pkg::REQ_FIND, sse_pkg::REQ_COUNT,
                        sse_pkg::REQ_REPLACE_FIRST, sse_pkg::REQ_REPLACE_ALL:
                        begin
                            state_next = ST_WALK;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (ctl_w[DEPTH].valid)
                begin
                    res_found_next = (ctl_w[DEPTH].op != sse_pkg::REQ_COUNT) &&
                                     ctl_w[DEPTH].hit;
                    res_pos_next   = (ctl_w[DEPTH].op == sse_pkg::REQ_COUNT) ?
                                     '0 : POS_W'(pos_w[DEPTH]);
                    res_cnt_next   = (ctl_w[DEPTH].op == sse_pkg::REQ_COUNT ||
                                      ctl_w[DEPTH].op == sse_pkg::REQ_REPLACE_ALL) ?
                                     MCH_W'(cnt_w[DEPTH]) : '0;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    // State, stack length and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
            res_cnt_reg   <= '0;
            res_err_reg   <= sse_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_pos_reg   <= '0;
            out_cnt_reg   <= '0;
            out_len_reg   <= '0;
            out_err_reg   <= sse_pkg::ERR_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_found_reg <= res_found_next;
            res_pos_reg   <= res_pos_next;
            res_cnt_reg   <= res_cnt_next;
            res_err_reg   <= res_err_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                out_found_reg <= res_found_reg;
                out_pos_reg   <= res_pos_reg;
                out_cnt_reg   <= res_cnt_reg;
                out_len_reg   <= LEN_W'(count_reg);
                out_err_reg   <= res_err_reg;
            end
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign position    = out_pos_reg;
    assign match_count = out_cnt_reg;
    assign length      = out_len_reg;
    assign error       = out_err_reg;

endmodule

/* test/searchable_stack_engine_core_tb.sv */
// Self-checking testbench for the searchable stack engine core.
`timescale 1ns / 100ps

module searchable_stack_engine_core_tb;

    import sse_pkg::*;

    localparam int DEPTH        = 16;
    localparam int DATA_W       = 32;
    localparam int RAND_ITEMS   = 1680;
    localparam int TAIL_ITEMS   = 150;
    localparam int PHASE_ITEMS  = 40;
    localparam int PRESS_AFTER  = 400;
    localparam int PRESS_CYCLES = 90;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

    // The two request codes that the block leaves unused.
    localparam req_t REQ_SPARE_LO = 3'd6;
    localparam req_t REQ_SPARE_HI = 3'd7;

    // Kinds of random phase, each with its own mix of requests.
    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED, PH_SAME_KEY} phase_kind_t;

    typedef struct {
        req_t              op;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] repl;
    } stack_req_t;

    typedef struct {
        logic                  found;
        logic [POSITION_W-1:0] position;
        logic [MATCH_W-1:0]    match_count;
        logic [LENGTH_W-1:0]   length;
        err_t                  error;
    } stack_rsp_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic [2:0]               req_type    = REQ_PUSH;
    logic signed [DATA_W-1:0] value       = '0;
    logic signed [DATA_W-1:0] new_value   = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic                     found;
    logic [3:0]               position;
    logic [4:0]               match_count;
    logic [4:0]               length;
    logic [1:0]               error;

    // Requests waiting to be offered and results the block still owes.
    stack_req_t pending_reqs[$];
    stack_rsp_t expected_rsps[$];

    // Shadow copy of the stack; slot 0 is the bottom entry.
    logic [DATA_W-1:0] shadow_mem [DEPTH];
    int                shadow_len = 0;

    int   mismatch_cnt = 0;
    int   accepted_cnt = 0;
    int   result_cnt   = 0;
    int   send_gap     = 0;
    int   send_calm    = 0;
    int   recv_gap     = 0;
    int   recv_calm    = 0;
    logic quiet_tail   = 1'b0;
    logic press_hold   = 1'b0;

    stack_req_t next_req;
    stack_rsp_t head_rsp;

    always #2 clk = ~clk;

    searchable_stack_engine_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .value       (value),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .position    (position),
        .match_count (match_count),
        .length      (length),
        .error       (error)
    );

    // Applies one request to the shadow stack and returns the result it owes.
    function automatic stack_rsp_t apply_request(input stack_req_t rq);
        stack_rsp_t rsp;
        logic       hit;
        logic       done;
        int         slot;
        rsp  = '{default: '0};
        hit  = 1'b0;
        done = 1'b0;
        case (rq.op)
            REQ_PUSH:
            begin
                if (shadow_len >= DEPTH)
                    rsp.error = ERR_FULL;
                else
                begin
                    shadow_mem[shadow_len] = rq.key;
                    shadow_len++;
                end
            end
            REQ_POP:
            begin
                if (shadow_len == 0)
                    rsp.error = ERR_EMPTY;
                else
                    shadow_len--;
            end
            REQ_FIND, REQ_COUNT, REQ_REPLACE_FIRST, REQ_REPLACE_ALL:
            begin
                // Walk from the top entry down to the bottom one.
                for (int i = 0; i < shadow_len && !done; i++)
                begin
                    slot = shadow_len - 1 - i;
                    if (shadow_mem[slot] == rq.key)
                    begin
                        if (!hit)
                        begin
                            hit = 1'b1;
                            rsp.position = POSITION_W'(i);
                            if (rq.op == REQ_REPLACE_FIRST)
                                shadow_mem[slot] = rq.repl;
                            if (rq.op == REQ_FIND || rq.op == REQ_REPLACE_FIRST)
                                done = 1'b1;
                        end
                        if (!done)
                        begin
                            rsp.match_count++;
                            if (rq.op == REQ_REPLACE_ALL)
                                shadow_mem[slot] = rq.repl;
                        end
                    end
                end
                if (rq.op != REQ_COUNT)
                    rsp.found = hit;
                else
                    rsp.position = '0;
                if (rq.op == REQ_FIND || rq.op == REQ_REPLACE_FIRST)
                    rsp.match_count = '0;
            end
            default:
            begin
            end
        endcase
        rsp.length = LENGTH_W'(shadow_len);
        return rsp;
    endfunction

    // Mostly keys from a small pool so that searches hit, sometimes any value.
    function automatic logic [DATA_W-1:0] pick_data();
        logic [DATA_W-1:0] pool [6];
        pool = '{32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h0000_0001, 32'h5a5a_a5a5};
        if ($urandom_range(0, 9) < 7)
            return pool[$urandom_range(0, 5)];
        return $urandom();
    endfunction

    function automatic stack_req_t rand_request(input phase_kind_t kind,
                                                input logic [DATA_W-1:0] phase_key);
        stack_req_t rq;
        int         roll;
        int         push_pct;
        int         pop_pct;
        case (kind)
            PH_GROW:     begin push_pct = 65; pop_pct = 10; end
            PH_SHRINK:   begin push_pct = 10; pop_pct = 60; end
            PH_SAME_KEY: begin push_pct = 70; pop_pct = 5;  end
            default:     begin push_pct = 35; pop_pct = 30; end
        endcase
        roll    = $urandom_range(0, 99);
        rq.key  = (kind == PH_SAME_KEY) ? phase_key : pick_data();
        rq.repl = ($urandom_range(0, 1) == 0) ? pick_data() : $urandom();
        if (roll < push_pct)
            rq.op = REQ_PUSH;
        else if (roll < push_pct + pop_pct)
            rq.op = REQ_POP;
        else if (roll < 98)
            rq.op = req_t'($urandom_range(REQ_FIND, REQ_REPLACE_ALL));
        else
            rq.op = ($urandom_range(0, 1) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
        return rq;
    endfunction

    task automatic add_req(input req_t op, input logic [DATA_W-1:0] key,
                           input logic [DATA_W-1:0] repl);
        stack_req_t rq;
        rq.op   = op;
        rq.key  = key;
        rq.repl = repl;
        pending_reqs.push_back(rq);
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", result_cnt, msg);
        mismatch_cnt++;
    endtask

    // Request driver: offers queued requests, holds them while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            req_type  <= REQ_PUSH;
            value     <= '0;
            new_value <= '0;
        end
        else
        begin
            quiet_tail <= (pending_reqs.size() < TAIL_ITEMS);
            if (send_calm > 0)
                send_calm--;
            else if ($urandom_range(0, 49) == 0)
                send_calm = $urandom_range(20, 80);

            // A beat was taken: predict its result and maybe start a gap.
            if (in_valid && !in_stall)
            begin
                expected_rsps.push_back(apply_request('{req_t'(req_type), value, new_value}));
                accepted_cnt++;
                if (!quiet_tail && send_calm == 0 && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 13);
            end

            if (in_valid && in_stall)
            begin
                // Hold the stalled beat as it is.
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                next_req  = pending_reqs.pop_front();
                in_valid  <= 1'b1;
                req_type  <= next_req.op;
                value     <= next_req.key;
                new_value <= next_req.repl;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor: checks each taken beat and stalls in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch("result beat with no request outstanding");
                else
                begin
                    head_rsp = expected_rsps.pop_front();
                    if (found !== head_rsp.found)
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  found, head_rsp.found));
                    if (position !== head_rsp.position)
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  position, head_rsp.position));
                    if (match_count !== head_rsp.match_count)
                        report_mismatch($sformatf("match_count %0d, expected %0d",
                                                  match_count, head_rsp.match_count));
                    if (length !== head_rsp.length)
                        report_mismatch($sformatf("length %0d, expected %0d",
                                                  length, head_rsp.length));
                    if (error !== head_rsp.error)
                        report_mismatch($sformatf("error %0d, expected %0d",
                                                  error, head_rsp.error));
                end
                result_cnt++;
            end

            if (recv_calm > 0)
                recv_calm--;
            else if ($urandom_range(0, 49) == 0)
                recv_calm = $urandom_range(20, 80);

            if (press_hold)
                out_stall <= 1'b1;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (!quiet_tail && recv_calm == 0 && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(0, 12);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Long receiver hold-off so that the block backs up into its input.
    initial
    begin
        wait (accepted_cnt >= PRESS_AFTER);
        @(posedge clk);
        press_hold <= 1'b1;
        repeat (PRESS_CYCLES) @(posedge clk);
        press_hold <= 1'b0;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial
    begin
        phase_kind_t       kind;
        logic [DATA_W-1:0] phase_key;
        int                left;

        // Directed part: empty-store cases, unused codes, extreme keys.
        add_req(REQ_POP, 32'h0, 32'h0);
        add_req(REQ_FIND, 32'h0, 32'h0);
        add_req(REQ_REPLACE_ALL, 32'h0, 32'h1);
        add_req(REQ_SPARE_LO, 32'h0, 32'h0);
        add_req(REQ_SPARE_HI, 32'hffff_ffff, 32'hffff_ffff);
        add_req(REQ_PUSH, 32'h8000_0000, 32'h0);
        add_req(REQ_PUSH, 32'h7fff_ffff, 32'h0);
        add_req(REQ_PUSH, 32'h8000_0000, 32'h0);
        add_req(REQ_PUSH, 32'hffff_ffff, 32'h0);
        add_req(REQ_PUSH, 32'h0000_0000, 32'h0);
        add_req(REQ_FIND, 32'h8000_0000, 32'h0);
        add_req(REQ_COUNT, 32'h8000_0000, 32'h0);
        add_req(REQ_REPLACE_FIRST, 32'h8000_0000, 32'h7fff_ffff);
        add_req(REQ_REPLACE_ALL, 32'h7fff_ffff, 32'h0000_0000);
        add_req(REQ_COUNT, 32'h0000_0000, 32'h0);
        add_req(REQ_FIND, 32'h1234_5678, 32'h0);
        add_req(REQ_REPLACE_FIRST, 32'h1234_5678, 32'hffff_ffff);
        add_req(REQ_SPARE_HI, 32'h0, 32'h0);
        add_req(REQ_POP, 32'h0, 32'h0);
        add_req(REQ_FIND, 32'h8000_0000, 32'h0);

        // Random part in phases that fill, drain or churn the stack.
        left = RAND_ITEMS;
        while (left > 0)
        begin
            kind      = phase_kind_t'($urandom_range(PH_GROW, PH_SAME_KEY));
            phase_key = pick_data();
            for (int n = 0; n < PHASE_ITEMS && left > 0; n++)
            begin
                pending_reqs.push_back(rand_request(kind, phase_key));
                left--;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && expected_rsps.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
